FILE: src/csrc_pkg.sv
// shared types, constants and codes of the cubic sample rate converter
package csrc_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int POS_W        = 20;
   localparam int FRAC_W       = 16;
   localparam int COUNT_W      = 2;
   localparam int CSR_DATA_W   = 20;
   localparam int CSR_INDEX_W  = 1;
   localparam int COEF_W       = 20;
   localparam int ACC_W        = 24;

   localparam int MAX_CHANNELS_DEF = 2;

   localparam logic [POS_W-1:0]   STEP_MIN   = 20'd8192;
   localparam logic [POS_W-1:0]   STEP_MAX   = 20'd524288;
   localparam logic [POS_W-1:0]   STEP_RESET = 20'd65536;
   localparam logic [POS_W-1:0]   POS_UNIT   = 20'd65536;
   localparam logic [COUNT_W-1:0] CHAN_RESET = 2'd2;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 1'd1;

   // multiply-add passes of the horner evaluation
   localparam logic [1:0] PASS_C1   = 2'd0;
   localparam logic [1:0] PASS_C2   = 2'd1;
   localparam logic [1:0] PASS_BASE = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_a;
      logic signed [SAMPLE_W-1:0] sample_b;
      logic                       end_of_stream;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] result_a;
      logic signed [SAMPLE_W-1:0] result_b;
      logic                       result_valid;
      logic                       last_result;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_COEF,
      ST_MULT,
      ST_PUSH,
      ST_MARK
   } state_type;

   // sequencer to frame window
   typedef struct packed {
      logic       load;
      logic       shift;
      logic       clear;
      logic [1:0] rd_idx;
   } win_ctl_type;

   // sequencer to multiply-add unit
   typedef struct packed {
      logic              fetch_en;
      logic [1:0]        fetch_sel;
      logic              coef_en;
      logic              ch;
      logic              mult_en;
      logic [1:0]        pass;
      logic [FRAC_W-1:0] frac;
   } mac_ctl_type;

   // sequencer to output register
   typedef struct packed {
      logic push;
      logic sample;
      logic last;
      logic keep_b;
   } out_ctl_type;

endpackage

FILE: src/csrc_window.sv
// frame window: three history frames and the frame being worked on
module csrc_window #(
   parameter int MAX_CHANNELS = csrc_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  csrc_pkg::win_ctl_type                ctl,
   input  csrc_pkg::req_type                    req_data,
   output logic signed [csrc_pkg::SAMPLE_W-1:0] rd_a,
   output logic signed [csrc_pkg::SAMPLE_W-1:0] rd_b
);
   import csrc_pkg::*;

   logic signed [SAMPLE_W-1:0] hist_a_ff [0:2];
   logic signed [SAMPLE_W-1:0] hist_a_in [0:2];
   logic signed [SAMPLE_W-1:0] cur_a_ff;
   logic signed [SAMPLE_W-1:0] cur_a_in;

   always_comb begin
      hist_a_in = hist_a_ff;
      cur_a_in  = cur_a_ff;
      if (ctl.load) begin
         cur_a_in = req_data.sample_a;
      end
      if (ctl.clear) begin
         hist_a_in[0] = '0;
         hist_a_in[1] = '0;
         hist_a_in[2] = '0;
      end else if (ctl.shift) begin
         hist_a_in[0] = hist_a_ff[1];
         hist_a_in[1] = hist_a_ff[2];
         hist_a_in[2] = cur_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_a_ff[0] <= '0;
         hist_a_ff[1] <= '0;
         hist_a_ff[2] <= '0;
      end else begin
         hist_a_ff <= hist_a_in;
      end
      cur_a_ff <= cur_a_in;
   end

   always_comb begin
      case (ctl.rd_idx)
         2'd0:    rd_a = hist_a_ff[0];
         2'd1:    rd_a = hist_a_ff[1];
         2'd2:    rd_a = hist_a_ff[2];
         default: rd_a = cur_a_ff;
      endcase
   end

   generate
      if (MAX_CHANNELS >= 2) begin : g_chan_b
         logic signed [SAMPLE_W-1:0] hist_b_ff [0:2];
         logic signed [SAMPLE_W-1:0] hist_b_in [0:2];
         logic signed [SAMPLE_W-1:0] cur_b_ff;
         logic signed [SAMPLE_W-1:0] cur_b_in;

         always_comb begin
            hist_b_in = hist_b_ff;
            cur_b_in  = cur_b_ff;
            if (ctl.load) begin
               cur_b_in = req_data.sample_b;
            end
            if (ctl.clear) begin
               hist_b_in[0] = '0;
               hist_b_in[1] = '0;
               hist_b_in[2] = '0;
            end else if (ctl.shift) begin
               hist_b_in[0] = hist_b_ff[1];
               hist_b_in[1] = hist_b_ff[2];
               hist_b_in[2] = cur_b_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               hist_b_ff[0] <= '0;
               hist_b_ff[1] <= '0;
               hist_b_ff[2] <= '0;
            end else begin
               hist_b_ff <= hist_b_in;
            end
            cur_b_ff <= cur_b_in;
         end

         always_comb begin
            case (ctl.rd_idx)
               2'd0:    rd_b = hist_b_ff[0];
               2'd1:    rd_b = hist_b_ff[1];
               2'd2:    rd_b = hist_b_ff[2];
               default: rd_b = cur_b_ff;
            endcase
         end
      end else begin : g_no_chan_b
         assign rd_b = '0;
      end
   endgenerate

endmodule

FILE: src/csrc_mac.sv
// catmull-rom evaluation on one shared multiply-add, three horner passes per channel
module csrc_mac (
   input  logic                                 clock,
   input  csrc_pkg::mac_ctl_type                ctl,
   input  logic signed [csrc_pkg::SAMPLE_W-1:0] rd_a,
   input  logic signed [csrc_pkg::SAMPLE_W-1:0] rd_b,
   output logic signed [csrc_pkg::SAMPLE_W-1:0] res_a,
   output logic signed [csrc_pkg::SAMPLE_W-1:0] res_b
);
   import csrc_pkg::*;

   localparam int PROD_W = FRAC_W + 1 + ACC_W;

   logic signed [SAMPLE_W-1:0] samp_a_ff [0:3];
   logic signed [SAMPLE_W-1:0] samp_b_ff [0:3];
   logic signed [COEF_W-1:0]   c0_ff, c1_ff, c2_ff, base_ff;
   logic signed [COEF_W-1:0]   c0_in, c1_in, c2_in, base_in;
   logic signed [COEF_W-1:0]   sm, s0, s1, s2;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    mul_op, add_op;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-2:0]    half;
   logic signed [SAMPLE_W-1:0] sat;
   logic signed [SAMPLE_W-1:0] res_a_ff, res_b_ff;

   // neighbor samples of the selected channel, widened for the coefficient sums
   always_comb begin
      if (ctl.ch) begin
         sm = COEF_W'(samp_b_ff[0]);
         s0 = COEF_W'(samp_b_ff[1]);
         s1 = COEF_W'(samp_b_ff[2]);
         s2 = COEF_W'(samp_b_ff[3]);
      end else begin
         sm = COEF_W'(samp_a_ff[0]);
         s0 = COEF_W'(samp_a_ff[1]);
         s1 = COEF_W'(samp_a_ff[2]);
         s2 = COEF_W'(samp_a_ff[3]);
      end
      // doubled coefficients
      c0_in   = -sm + (s0 <<< 1) + s0 - (s1 <<< 1) - s1 + s2;
      c1_in   = (sm <<< 1) - (s0 <<< 2) - s0 + (s1 <<< 2) - s2;
      c2_in   = s1 - sm;
      base_in = s0 <<< 1;
   end

   always_comb begin
      case (ctl.pass)
         PASS_C1: begin
            mul_op = ACC_W'(c0_ff);
            add_op = ACC_W'(c1_ff);
         end
         PASS_C2: begin
            mul_op = acc_ff;
            add_op = ACC_W'(c2_ff);
         end
         default: begin
            mul_op = acc_ff;
            add_op = ACC_W'(base_ff);
         end
      endcase
      prod   = PROD_W'($signed({1'b0, ctl.frac})) * PROD_W'(mul_op);
      // arithmetic shift of the product is the floor division by 2^16
      acc_in = add_op + $signed(prod[FRAC_W+ACC_W-1:FRAC_W]);
      half   = acc_in[ACC_W-1:1];
      if (half > (ACC_W-1)'(32767)) begin
         sat = 16'sd32767;
      end else if (half < -(ACC_W-1)'(32768)) begin
         sat = -16'sd32768;
      end else begin
         sat = half[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fetch_en) begin
         samp_a_ff[ctl.fetch_sel] <= rd_a;
         samp_b_ff[ctl.fetch_sel] <= rd_b;
      end
      if (ctl.coef_en) begin
         c0_ff   <= c0_in;
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         base_ff <= base_in;
      end
      if (ctl.mult_en) begin
         acc_ff <= acc_in;
         if (ctl.pass == PASS_BASE) begin
            if (ctl.ch) begin
               res_b_ff <= sat;
            end else begin
               res_a_ff <= sat;
            end
         end
      end
   end

   assign res_a = res_a_ff;
   assign res_b = res_b_ff;

endmodule

FILE: src/csrc_seq.sv
// sequencer: output positions, neighbor fetch, horner passes and stream bookkeeping
module csrc_seq #(
   parameter int MAX_CHANNELS = csrc_pkg::MAX_CHANNELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_eos,
   input  logic [csrc_pkg::POS_W-1:0]         phase_step,
   input  logic [csrc_pkg::COUNT_W-1:0]       channel_count,
   input  logic                               out_free,
   output csrc_pkg::win_ctl_type              win_ctl,
   output csrc_pkg::mac_ctl_type              mac_ctl,
   output csrc_pkg::out_ctl_type              out_ctl
);
   import csrc_pkg::*;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   next_pos_ff, next_pos_in;
   logic [COUNT_W-1:0] fs_ff, fs_in;
   logic [POS_W-1:0]   step_ff, step_in;
   logic               stereo_ff, stereo_in;
   logic               eos_ff, eos_in;
   logic               emitted_ff, emitted_in;
   logic [1:0]         j_ff, j_in;
   logic               ch_ff, ch_in;
   logic [1:0]         pass_ff, pass_in;

   logic [POS_W-1:0]   pos_step;
   logic signed [5:0]  baseoff;
   logic signed [5:0]  thresh;
   logic signed [5:0]  ko;
   logic signed [5:0]  off;
   logic signed [5:0]  lo;
   logic               brk;
   logic               brk_next;

   always_comb begin
      baseoff  = (fs_ff >= 2'd2) ? 6'sd2 : $signed({4'd0, fs_ff});
      thresh   = baseoff - (eos_ff ? 6'sd0 : 6'sd2);
      pos_step = pos_ff + step_ff;
      brk      = $signed({2'd0, pos_ff[POS_W-1:FRAC_W]}) > thresh;
      brk_next = $signed({2'd0, pos_step[POS_W-1:FRAC_W]}) > thresh;
      // frame of neighbor j, clamped to the frames held, as a window slot
      ko  = $signed({2'd0, pos_ff[POS_W-1:FRAC_W]}) - baseoff;
      off = ko - 6'sd1 + $signed({4'd0, j_ff});
      lo  = -$signed({4'd0, fs_ff});
      if (off < lo) begin
         off = lo;
      end
      if (off > 6'sd0) begin
         off = 6'sd0;
      end
      off = off + 6'sd3;
   end

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      next_pos_in = next_pos_ff;
      fs_in       = fs_ff;
      step_in     = step_ff;
      stereo_in   = stereo_ff;
      eos_in      = eos_ff;
      emitted_in  = emitted_ff;
      j_in        = j_ff;
      ch_in       = ch_ff;
      pass_in     = pass_ff;

      req_ready = 1'b0;
      win_ctl   = '0;
      mac_ctl   = '0;
      out_ctl   = '0;

      win_ctl.rd_idx    = off[1:0];
      mac_ctl.fetch_sel = j_ff;
      mac_ctl.ch        = ch_ff;
      mac_ctl.pass      = pass_ff;
      mac_ctl.frac      = pos_ff[FRAC_W-1:0];
      out_ctl.keep_b    = stereo_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               win_ctl.load = 1'b1;
               pos_in       = next_pos_ff;
               eos_in       = req_eos;
               emitted_in   = 1'b0;
               stereo_in    = (MAX_CHANNELS >= 2) && (channel_count >= 2'd2);
               if (phase_step < STEP_MIN) begin
                  step_in = STEP_MIN;
               end else if (phase_step > STEP_MAX) begin
                  step_in = STEP_MAX;
               end else begin
                  step_in = phase_step;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!brk) begin
               j_in     = 2'd0;
               state_in = ST_FETCH;
            end else if (eos_ff) begin
               if (!emitted_ff) begin
                  state_in = ST_MARK;
               end else begin
                  win_ctl.clear = 1'b1;
                  fs_in         = '0;
                  next_pos_in   = '0;
                  state_in      = ST_IDLE;
               end
            end else begin
               win_ctl.shift = 1'b1;
               next_pos_in   = (fs_ff >= 2'd2) ? pos_ff - POS_UNIT : pos_ff;
               if (fs_ff != 2'd3) begin
                  fs_in = fs_ff + 2'd1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            mac_ctl.fetch_en = 1'b1;
            j_in             = j_ff + 2'd1;
            if (j_ff == 2'd3) begin
               ch_in    = 1'b0;
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            mac_ctl.coef_en = 1'b1;
            pass_in         = PASS_C1;
            state_in        = ST_MULT;
         end
         ST_MULT: begin
            mac_ctl.mult_en = 1'b1;
            pass_in         = pass_ff + 2'd1;
            if (pass_ff == PASS_BASE) begin
               if (stereo_ff && !ch_ff) begin
                  ch_in    = 1'b1;
                  state_in = ST_COEF;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               out_ctl.push   = 1'b1;
               out_ctl.sample = 1'b1;
               out_ctl.last   = eos_ff && brk_next;
               pos_in         = pos_step;
               emitted_in     = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_MARK: begin
            if (out_free) begin
               out_ctl.push  = 1'b1;
               out_ctl.last  = 1'b1;
               win_ctl.clear = 1'b1;
               fs_in         = '0;
               next_pos_in   = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         next_pos_ff <= '0;
         fs_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         next_pos_ff <= next_pos_in;
         fs_ff       <= fs_in;
      end
      pos_ff     <= pos_in;
      step_ff    <= step_in;
      stereo_ff  <= stereo_in;
      eos_ff     <= eos_in;
      emitted_ff <= emitted_in;
      j_ff       <= j_in;
      ch_ff      <= ch_in;
      pass_ff    <= pass_in;
   end

endmodule

FILE: src/cubic_sample_rate_converter_top.sv
// top level of the catmull-rom cubic sample rate converter
// Takes one frame at a time and answers with zero or more interpolated frames. A frame
// is accepted and ends with a final position check; each output it yields takes a
// position check, a fetch of the four neighbors, per channel the coefficients and then
// three horner passes on the shared multiply-add, and a push that waits for a free
// output register. An empty end marker takes a push of its own. The result sits in an
// output register, so the sequencer works on the next output while it waits.
// The final frame of a stream flushes the remaining outputs, or an empty marker, and
// the stream state returns to its reset values. Write registers only while idle; a new
// step or channel count is picked up at the next accepted frame.
module cubic_sample_rate_converter_top #(
   parameter int MAX_CHANNELS = csrc_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  csrc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output csrc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_wr_en,
   input  logic [csrc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [csrc_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import csrc_pkg::*;

   logic [POS_W-1:0]           phase_step_ff, phase_step_in;
   logic [COUNT_W-1:0]         channel_count_ff, channel_count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;
   logic                       out_free;
   win_ctl_type                win_ctl;
   mac_ctl_type                mac_ctl;
   out_ctl_type                out_ctl;
   logic signed [SAMPLE_W-1:0] rd_a, rd_b;
   logic signed [SAMPLE_W-1:0] res_a, res_b;

   always_comb begin
      phase_step_in    = phase_step_ff;
      channel_count_in = channel_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PHASE_STEP:    phase_step_in    = csr_wdata[POS_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // output register: a new transaction loads when the slot is empty or being taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (out_ctl.push) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.result_valid = out_ctl.sample;
         rsp_data_in.last_result  = out_ctl.last;
         rsp_data_in.result_a     = out_ctl.sample ? res_a : '0;
         rsp_data_in.result_b     = (out_ctl.sample && out_ctl.keep_b) ? res_b : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff    <= STEP_RESET;
         channel_count_ff <= CHAN_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_step_ff    <= phase_step_in;
         channel_count_ff <= channel_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   csrc_window #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .ctl      (win_ctl),
      .req_data (req_data),
      .rd_a     (rd_a),
      .rd_b     (rd_b)
   );

   csrc_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .rd_a  (rd_a),
      .rd_b  (rd_b),
      .res_a (res_a),
      .res_b (res_b)
   );

   csrc_seq #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_eos       (req_data.end_of_stream),
      .phase_step    (phase_step_ff),
      .channel_count (channel_count_ff),
      .out_free      (out_free),
      .win_ctl       (win_ctl),
      .mac_ctl       (mac_ctl),
      .out_ctl       (out_ctl)
   );

endmodule

FILE: dv/cubic_sample_rate_converter_top_tb.sv
// self-checking testbench of the cubic sample rate converter with a built-in resampling predictor
module cubic_sample_rate_converter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csrc_pkg::*;

   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AT       = 120;
   localparam int RANDOM_FRAMES = 230;
   localparam int MAX_PER_FRAME = 24;
   localparam int PRINT_CAP     = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PHASE_STEP;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   cubic_sample_rate_converter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // frames waiting to be offered and interpolated outputs waiting to arrive
   req_type pending_frames[$];
   rsp_type predicted_outputs[$];

   int frames_queued   = 0;
   int frames_accepted = 0;
   int results_seen    = 0;
   int markers_seen    = 0;
   int settings_used   = 0;
   int mismatches      = 0;
   int idle_cycles     = 0;
   logic req_fire      = 1'b0;

   // predictor copy of the registers and of the stream state
   logic [POS_W-1:0]          cfg_step  = STEP_RESET;
   logic [COUNT_W-1:0]        cfg_chans = CHAN_RESET;
   logic signed [SAMPLE_W-1:0] hist[6];
   int                        frames_in_stream = 0;
   logic [POS_W-1:0]          out_pos = '0;

   // no idling on either side while this window of transactions goes by
   logic calm;
   assign calm = (frames_accepted >= 110) && (frames_accepted < 170);

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] catmull_point(
      input longint sm, input longint s0, input longint s1, input longint s2,
      input longint t);
      longint c0, c1, c2, u, v, w, y;
      c0 = -sm + 3 * s0 - 3 * s1 + s2;
      c1 = 2 * sm - 5 * s0 + 4 * s1 - s2;
      c2 = s1 - sm;
      // arithmetic shifts of signed values round toward minus infinity
      u = c1 + ((t * c0) >>> 16);
      v = c2 + ((t * u) >>> 16);
      w = 2 * s0 + ((t * v) >>> 16);
      y = w >>> 1;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      return y[SAMPLE_W-1:0];
   endfunction

   task automatic resample_frame(input req_type f);
      longint win[4][2];
      longint s[4];
      logic signed [SAMPLE_W-1:0] r[2];
      int unsigned stp, d;
      int fs, baseoff, limit, ko, o, cnt;
      bit stereo;
      rsp_type item;
      fs      = frames_in_stream;
      baseoff = (fs >= 2) ? 2 : fs;
      limit   = f.end_of_stream ? 0 : -2;
      stereo  = (MAX_CHANNELS_DEF >= 2) && (cfg_chans >= 2);
      stp     = cfg_step;
      d       = out_pos;
      cnt     = 0;
      if (stp < STEP_MIN) stp = STEP_MIN;
      if (stp > STEP_MAX) stp = STEP_MAX;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = hist[2*i];
         win[i][1] = hist[2*i+1];
      end
      win[3][0] = f.sample_a;
      win[3][1] = f.sample_b;
      while (cnt < MAX_PER_FRAME) begin
         ko = int'(d >> 16) - baseoff;
         if (ko > limit) break;
         for (int ch = 0; ch < 2; ch++) begin
            for (int j = 0; j < 4; j++) begin
               // neighbors clamp to the first frame and to the newest frame
               o = ko - 1 + j;
               if (o < -fs) o = -fs;
               if (o > 0) o = 0;
               if (o < -3) o = -3;
               s[j] = win[3+o][ch];
            end
            r[ch] = catmull_point(s[0], s[1], s[2], s[3], longint'(d & 32'hFFFF));
         end
         item.result_a     = r[0];
         item.result_b     = stereo ? r[1] : '0;
         item.result_valid = 1'b1;
         item.last_result  = 1'b0;
         predicted_outputs = {predicted_outputs, item};
         cnt++;
         d += stp;
      end
      if (f.end_of_stream) begin
         if (cnt == 0) begin
            // nothing left to flush: empty end marker
            item = '0;
            item.last_result = 1'b1;
            predicted_outputs = {predicted_outputs, item};
         end else begin
            predicted_outputs[predicted_outputs.size()-1].last_result = 1'b1;
         end
         foreach (hist[i]) hist[i] = '0;
         frames_in_stream = 0;
         out_pos = '0;
      end else begin
         for (int i = 0; i < 4; i++) hist[i] = hist[i+2];
         hist[4] = f.sample_a;
         hist[5] = f.sample_b;
         if (fs >= 2) d -= POS_UNIT;
         out_pos = d[POS_W-1:0];
         if (frames_in_stream < 3) frames_in_stream++;
      end
   endtask

   // monitor: predicts on accepted frames and checks accepted results
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (req_valid && req_ready) begin
            resample_frame(req_data);
            frames_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (!rsp_data.result_valid) markers_seen++;
            if (predicted_outputs.size() == 0) begin
               report_mismatch("unexpected result, result_a", rsp_data.result_a, 0);
            end else begin
               rsp_type want;
               want = predicted_outputs.pop_front();
               if (rsp_data.result_a !== want.result_a)
                  report_mismatch("result_a", rsp_data.result_a, want.result_a);
               if (rsp_data.result_b !== want.result_b)
                  report_mismatch("result_b", rsp_data.result_b, want.result_b);
               if (rsp_data.result_valid !== want.result_valid)
                  report_mismatch("result_valid", rsp_data.result_valid, want.result_valid);
               if (rsp_data.last_result !== want.last_result)
                  report_mismatch("last_result", rsp_data.last_result, want.last_result);
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, predicted_outputs.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // driver of the frame channel
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_frames.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
            req_data  <= pending_frames.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver with one long hold-off so the block backs up
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 17);
      end
   end

   task automatic queue_frame(input logic [15:0] a, input logic [15:0] b, input bit eos);
      req_type f;
      f.sample_a      = a;
      f.sample_b      = b;
      f.end_of_stream = eos;
      pending_frames = {pending_frames, f};
      frames_queued++;
   endtask

   task automatic set_rates(input logic [POS_W-1:0] step, input logic [COUNT_W-1:0] chans);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PHASE_STEP;
      csr_wdata <= step;
      @(negedge clock);
      csr_index <= CSR_CHANNEL_COUNT;
      csr_wdata <= CSR_DATA_W'(chans);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_step  = step;
      cfg_chans = chans;
      settings_used++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (frames_accepted != frames_queued || predicted_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int random_frames;
      int len;
      logic [POS_W-1:0] step;
      foreach (hist[i]) hist[i] = '0;
      random_frames = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unit step passes extremes straight through
      queue_frame(16'h7FFF, 16'h8000, 1'b0);
      queue_frame(16'h8000, 16'h7FFF, 1'b0);
      queue_frame(16'h7FFF, 16'h7FFF, 1'b0);
      queue_frame(16'h8000, 16'h8000, 1'b0);
      queue_frame(16'h0000, 16'h0000, 1'b0);
      queue_frame(16'h7FFF, 16'h8000, 1'b1);
      wait_idle();

      // fractional positions between full-scale swings overshoot and saturate
      set_rates(20'd98304, 2'd2);
      queue_frame(16'h7FFF, 16'h8000, 1'b0);
      queue_frame(16'h8000, 16'h7FFF, 1'b0);
      queue_frame(16'h7FFF, 16'h8000, 1'b0);
      queue_frame(16'h8000, 16'h7FFF, 1'b0);
      queue_frame(16'h7FFF, 16'h8000, 1'b1);
      wait_idle();

      // largest step: final frame has nothing left, then a one-frame stream
      set_rates(STEP_MAX, 2'd1);
      queue_frame(16'h1234, 16'hFEDC, 1'b0);
      queue_frame(16'h4000, 16'hC000, 1'b0);
      queue_frame(16'h8000, 16'h7FFF, 1'b0);
      queue_frame(16'h7FFF, 16'h8000, 1'b1);
      queue_frame(16'hABCD, 16'h5432, 1'b1);
      wait_idle();

      // step below range is raised to the minimum, channel count 3 is stereo
      set_rates(20'd0, 2'd3);
      queue_frame(16'h7FFF, 16'h0001, 1'b0);
      queue_frame(16'h8000, 16'hFFFF, 1'b0);
      queue_frame(16'h0100, 16'h7FFF, 1'b0);
      queue_frame(16'hFF00, 16'h8000, 1'b1);
      wait_idle();

      // step above range is lowered to the maximum, channel count 0 is mono
      set_rates(20'hFFFFF, 2'd0);
      queue_frame(16'h7FFF, 16'h7FFF, 1'b0);
      queue_frame(16'h8000, 16'h8000, 1'b1);
      wait_idle();

      while (random_frames < RANDOM_FRAMES) begin
         case ($urandom_range(9))
            0: step = POS_W'($urandom_range(8191, 0));
            1: step = POS_W'($urandom_range(1048575, 524289));
            2: step = POS_UNIT;
            3: step = STEP_MAX;
            4: step = STEP_MIN;
            default: step = POS_W'($urandom_range(200000, 8192));
         endcase
         set_rates(step, 2'($urandom_range(3)));
         repeat (4) begin
            len = $urandom_range(10, 1);
            for (int i = 0; i < len; i++)
               queue_frame(pick_sample(), pick_sample(), i == len - 1);
            random_frames += len;
         end
         wait_idle();
      end

      $display("covered %0d frames under %0d register settings", frames_accepted, settings_used);
      $display("checked %0d results, %0d of them empty end markers", results_seen, markers_seen);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
